// ===== rtl/etm_pkg.sv =====
`default_nettype none
package etm_pkg;
	localparam int CordicIters = 30;
	localparam int AngW = 36;
	localparam int CW = 34;
	localparam logic signed [AngW-1:0] AngPi = 36'sh0C90FDAA2;
	localparam logic signed [AngW-1:0] AngTwoPi = 36'sh1921FB544;
	localparam logic signed [AngW-1:0] AngHalfPi = 36'sh06487ED51;
	localparam logic signed [CW-1:0] CordicGain = 34'sh026DD3B6A;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AngW-1:0] a;
		logic flip;
	} cordic_t;

	function automatic logic signed [AngW-1:0] atan_val(input logic [4:0] i);
		logic signed [AngW-1:0] r;
		begin
			case (i)
				5'd0: r = 36'sh03243F6A8;
				5'd1: r = 36'sh01DAC6705;
				5'd2: r = 36'sh00FADBAFC;
				5'd3: r = 36'sh007F56EA6;
				5'd4: r = 36'sh003FEAB76;
				5'd5: r = 36'sh001FFD55B;
				5'd6: r = 36'sh000FFFAAA;
				5'd7: r = 36'sh0007FFF55;
				5'd8: r = 36'sh0003FFFEA;
				5'd9: r = 36'sh0001FFFFD;
				5'd10: r = 36'sh0000FFFFF;
				default: r = AngW'(64'sd1 <<< (30 - int'(i)));
			endcase
			atan_val = r;
		end
	endfunction
endpackage
`default_nettype wire

// ===== rtl/euler_trs_model_matrix.sv =====
// Model matrix builder: T * Rz(roll) * Ry(yaw) * Rx(pitch) * S.
// s_axis: one transaction per item (position, angles, scales).
// m_axis: four transactions per item, columns 0..3, tlast on column 3.
// Sine/cosine by three 30-stage pipelined CORDIC units, then product,
// rounding and scaling stages; columns 1..3 follow column 0 in order.
// The column serializer on the output (four columns share one output
// port) bounds throughput: while it sends an item, no new item enters
// before its last column is taken. While the output is idle an item
// enters every cycle. The pipeline advances only when its last stage
// is free, so a stalled receiver holds everything and no transaction
// is lost or repeated.
// Reset clears all valid bits; payload is not reset.
`default_nettype none
module euler_trs_model_matrix
	import etm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// pos_x, pos_y, pos_z, yaw, pitch, roll, scale_x, scale_y, scale_z
	input wire logic [239:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// column_index, row0..row3 (2+128 bits, zero-padded to 136)
	output logic [135:0] m_axis_tdata,
	output logic m_axis_tlast
);
	localparam int D = CordicIters + 2;
	logic en;
	logic [D-1:0] v_q;
	logic [191:0] pay_q [0:D-1];
	logic signed [17:0] sy, cy, sp, cp, sr, cr;

	// serializer
	logic busy_q;
	logic [1:0] col_q;
	logic signed [31:0] out_q [0:8];
	logic [95:0] pos_q;

	assign en = !busy_q || (col_q == 2'd3 && m_axis_tready);
	assign s_axis_tready = en;

	etm_sincos u_y(.clk, .en, .angle(s_axis_tdata[111:96]), .sin_q(sy), .cos_q(cy));
	etm_sincos u_p(.clk, .en, .angle(s_axis_tdata[127:112]), .sin_q(sp), .cos_q(cp));
	etm_sincos u_r(.clk, .en, .angle(s_axis_tdata[143:128]), .sin_q(sr), .cos_q(cr));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[D-2:0], s_axis_tvalid};
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pay_q[0] <= {s_axis_tdata[239:144], s_axis_tdata[95:0]};
			for (int k = 1; k < D; k++) pay_q[k] <= pay_q[k-1];
		end
	end

	// stage 1: pairwise products Q.32
	logic signed [33:0] crcy_s1, srcy_s1, crsp_s1, srcp_s1, srsp_s1, crcp_s1, spcy_s1, cpcy_s1;
	logic signed [17:0] sy_s1;
	logic v_s1;
	logic [191:0] pay_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= v_q[D-1];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			crcy_s1 <= 34'(cr * cy); srcy_s1 <= 34'(sr * cy);
			crsp_s1 <= 34'(cr * sp); srcp_s1 <= 34'(sr * cp);
			srsp_s1 <= 34'(sr * sp); crcp_s1 <= 34'(cr * cp);
			spcy_s1 <= 34'(sp * cy); cpcy_s1 <= 34'(cp * cy);
			sy_s1 <= sy;
			pay_s1 <= pay_q[D-1];
		end
	end

	// stage 2: rotation entries at Q.48 -> Q.30
	logic signed [33:0] rq_s2 [0:8];
	logic signed [63:0] r48 [0:8];
	logic v_s2;
	logic [191:0] pay_s2;
	always_comb begin
		r48[0] = 64'(crcy_s1) <<< 16;
		r48[1] = 64'(srcy_s1) <<< 16;
		r48[2] = -(64'(sy_s1) <<< 32);
		r48[3] = 64'(crsp_s1) * 64'(sy_s1) - (64'(srcp_s1) <<< 16);
		r48[4] = 64'(srsp_s1) * 64'(sy_s1) + (64'(crcp_s1) <<< 16);
		r48[5] = 64'(spcy_s1) <<< 16;
		r48[6] = 64'(crcp_s1) * 64'(sy_s1) + (64'(srsp_s1) <<< 16);
		r48[7] = 64'(srcp_s1) * 64'(sy_s1) - (64'(crsp_s1) <<< 16);
		r48[8] = 64'(cpcy_s1) <<< 16;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) rq_s2[k] <= 34'((r48[k] + 64'sd131072) >>> 18);
			pay_s2 <= pay_s1;
		end
	end

	// stage 3: scale and saturate
	logic signed [31:0] scl [0:2];
	logic signed [31:0] sat [0:8];
	logic signed [65:0] pr;
	always_comb begin
		scl[0] = pay_s2[127:96]; scl[1] = pay_s2[159:128]; scl[2] = pay_s2[191:160];
		for (int j = 0; j < 3; j++) begin
			for (int r = 0; r < 3; r++) begin
				pr = (66'(rq_s2[j*3+r]) * 66'(scl[j]) + (66'sd1 <<< 29)) >>> 30;
				sat[j*3+r] = (pr > 66'sh7FFFFFFF) ? 32'sh7FFFFFFF :
					(pr < -66'sh80000000) ? 32'sh80000000 : 32'(pr);
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q <= '0;
		end else if (en) begin
			busy_q <= v_s2;
			col_q <= '0;
		end else if (m_axis_tready) begin
			col_q <= col_q + 2'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) out_q[k] <= sat[k];
			pos_q <= pay_s2[95:0];
		end
	end

	logic [31:0] r0, r1, r2, r3;
	always_comb begin
		case (col_q)
			2'd0: begin r0 = out_q[0]; r1 = out_q[1]; r2 = out_q[2]; r3 = '0; end
			2'd1: begin r0 = out_q[3]; r1 = out_q[4]; r2 = out_q[5]; r3 = '0; end
			2'd2: begin r0 = out_q[6]; r1 = out_q[7]; r2 = out_q[8]; r3 = '0; end
			default: begin
				r0 = pos_q[31:0]; r1 = pos_q[63:32]; r2 = pos_q[95:64]; r3 = 32'd65536;
			end
		endcase
	end
	assign m_axis_tvalid = busy_q;
	assign m_axis_tlast = (col_q == 2'd3);
	assign m_axis_tdata = {6'd0, r3, r2, r1, r0, col_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(col_q)) else $error("col moved");
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!busy_q || m_axis_tlast)) else $error("ready early");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid) else $error("gap");
endmodule
`default_nettype wire

// ===== rtl/etm_sincos.sv =====
`default_nettype none
module etm_sincos
	import etm_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic signed [15:0] angle,
	output logic signed [17:0] sin_q,
	output logic signed [17:0] cos_q
);
	cordic_t cs_q [0:CordicIters];
	cordic_t red;
	logic signed [AngW-1:0] a0;

	always_comb begin
		a0 = AngW'(angle) <<< 18;
		if (a0 > AngPi) a0 = a0 - AngTwoPi;
		else if (a0 < -AngPi) a0 = a0 + AngTwoPi;
		red.x = CordicGain;
		red.y = '0;
		red.flip = 1'b0;
		red.a = a0;
		if (a0 > AngHalfPi) begin
			red.a = AngPi - a0;
			red.flip = 1'b1;
		end else if (a0 < -AngHalfPi) begin
			red.a = -AngPi - a0;
			red.flip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) cs_q[0] <= red;
	end

	for (genvar i = 0; i < CordicIters; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				cs_q[i+1].flip <= cs_q[i].flip;
				if (cs_q[i].a >= 0) begin
					cs_q[i+1].x <= cs_q[i].x - (cs_q[i].y >>> i);
					cs_q[i+1].y <= cs_q[i].y + (cs_q[i].x >>> i);
					cs_q[i+1].a <= cs_q[i].a - atan_val(5'(i));
				end else begin
					cs_q[i+1].x <= cs_q[i].x + (cs_q[i].y >>> i);
					cs_q[i+1].y <= cs_q[i].y - (cs_q[i].x >>> i);
					cs_q[i+1].a <= cs_q[i].a + atan_val(5'(i));
				end
			end
		end
	end

	logic signed [CW-1:0] sr, cr;
	logic signed [17:0] sc, cc;
	always_comb begin
		sr = (cs_q[CordicIters].y + CW'(8192)) >>> 14;
		cr = (cs_q[CordicIters].x + CW'(8192)) >>> 14;
		sc = (sr > 65536) ? 18'sd65536 : (sr < -65536) ? -18'sd65536 : 18'(sr);
		cc = (cr > 65536) ? 18'sd65536 : (cr < -65536) ? -18'sd65536 : 18'(cr);
		if (cs_q[CordicIters].flip) cc = -cc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_q <= sc;
			cos_q <= cc;
		end
	end
endmodule
`default_nettype wire
